// File: sv/gdfc_pkg.sv
package gdfc_pkg;

    // Fixed field widths
    localparam int OUT_W      = 32;
    localparam int TAG_W      = 16;
    localparam int PC_W       = 2;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register map (word index taken from paddr[2])
    localparam logic [0:0] REG_PASS_COUNT = 1'b0;

    // pass_count codes
    localparam logic [PC_W-1:0] PASS_ONE   = 2'd1;
    localparam logic [PC_W-1:0] PASS_TWO   = 2'd2;

    // Kernel magnitudes |k[a]| for sigma 5, Q0.24
    localparam int TABLE_FRAC = 24;
    localparam int MAG_LAST   = 15;
    localparam logic [17:0] DOG_MAG [0:MAG_LAST] = '{
        18'd0,      18'd52485,  18'd98857,  18'd134174,
        18'd155527, 18'd162384, 18'd156379, 18'd140673,
        18'd119100, 18'd95369,  18'd72465,  18'd52375,
        18'd36069,  18'd23700,  18'd14874,  18'd8922
    };

    // Signed tap weight for window offset off (older samples: negative off,
    // positive weight), rescaled to frac fractional bits.
    function automatic logic signed [31:0] dog_weight(input int off, input int frac);
        int          a;
        int          s;
        logic [31:0] m;
        a = (off < 0) ? -off : off;
        s = frac - TABLE_FRAC;
        if (a > MAG_LAST) begin
            m = '0;
        end else begin
            m = 32'(DOG_MAG[a[3:0]]);
        end
        if (s >= 0) begin
            m = m << s;
        end else begin
            m = m >> (-s);
        end
        return (off < 0) ? $signed(m) : -$signed(m);
    endfunction

endpackage

// File: sv/gdfc_in_if.sv
interface gdfc_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [SAMPLE_WIDTH-1:0]       sample;
    logic [gdfc_pkg::TAG_W-1:0]    position;
    logic                          line_start;

    modport source (output valid, output sample, output position, output line_start,
                    input ready);
    modport sink   (input valid, input sample, input position, input line_start,
                    output ready);
endinterface

// File: sv/gdfc_out_if.sv
interface gdfc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [gdfc_pkg::OUT_W-1:0]  filtered_value;
    logic [gdfc_pkg::TAG_W-1:0]         out_position;

    modport source (output valid, output filtered_value, output out_position,
                    input ready);
    modport sink   (input valid, input filtered_value, input out_position,
                    output ready);
endinterface

// File: sv/gdfc_cell.sv
// One tap of a transposed-form FIR: holds a partial sum, adds its own
// weighted copy of the broadcast input, hands the sum to the next cell.
module gdfc_cell #(
    parameter int                 IN_W   = 17,
    parameter int                 WGT_W  = 20,
    parameter int                 ACC_W  = 42,
    parameter logic signed [31:0] WEIGHT = 32'sd0
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [IN_W-1:0]  i_x,
    input  logic signed [ACC_W-1:0] i_psum,
    output logic signed [ACC_W-1:0] o_psum
);
    localparam logic signed [WGT_W-1:0] C_WGT = WGT_W'(WEIGHT);

    logic signed [IN_W+WGT_W-1:0] prod;
    logic signed [ACC_W-1:0]      n_psum;
    logic signed [ACC_W-1:0]      r_psum;

    assign prod   = i_x * C_WGT;
    assign n_psum = ACC_W'(prod) + i_psum;

    // partial sum advances only on a real beat
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_psum <= n_psum;
        end
    end

    assign o_psum = r_psum;
endmodule

// File: sv/gdfc_pass.sv
// One filter pass: a row of tap cells plus the head tap, the scaling
// shift and 32-bit saturation. Result is registered on each beat.
module gdfc_pass #(
    parameter int IN_W           = 17,
    parameter int HALF_TAPS      = 15,
    parameter int COEF_FRAC_BITS = 24,
    parameter int SHIFT          = 8
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [IN_W-1:0]            i_x,
    output logic signed [gdfc_pkg::OUT_W-1:0] o_y
);
    localparam int TAPS  = 2 * HALF_TAPS + 1;
    localparam int WGT_W = COEF_FRAC_BITS - 4;
    localparam int ACC_W = IN_W + WGT_W + $clog2(TAPS);
    localparam int OUT_W = gdfc_pkg::OUT_W;
    localparam logic signed [WGT_W-1:0] C_HEAD =
        WGT_W'(gdfc_pkg::dog_weight(HALF_TAPS, COEF_FRAC_BITS));
    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
    localparam logic signed [OUT_W-1:0] Y_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] Y_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic signed [ACC_W-1:0]           psum [1:TAPS];
    logic signed [IN_W+WGT_W-1:0]      head_prod;
    logic signed [ACC_W-1:0]           acc;
    logic signed [63:0]                acc_ext;
    logic signed [63:0]                scaled;
    logic signed [OUT_W-1:0]           n_y;
    logic signed [OUT_W-1:0]           r_y;

    assign psum[TAPS] = '0;

    // cell j weights the sample j beats old
    for (genvar j = 1; j < TAPS; j++) begin : g_cell
        gdfc_cell #(
            .IN_W   (IN_W),
            .WGT_W  (WGT_W),
            .ACC_W  (ACC_W),
            .WEIGHT (gdfc_pkg::dog_weight(HALF_TAPS - j, COEF_FRAC_BITS))
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_x    (i_x),
            .i_psum (psum[j+1]),
            .o_psum (psum[j])
        );
    end

    // head tap, floor shift, saturate
    assign head_prod = i_x * C_HEAD;
    assign acc       = ACC_W'(head_prod) + psum[1];
    assign acc_ext   = 64'(acc);
    assign scaled    = acc_ext >>> SHIFT;

    always_comb begin
        if (scaled > SAT_MAX) begin
            n_y = Y_MAX;
        end else if (scaled < SAT_MIN) begin
            n_y = Y_MIN;
        end else begin
            n_y = OUT_W'(scaled);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;
endmodule

// File: sv/gaussian_derivative_fir_cascade.sv
// Accepted input beat to result beat: pass 1 register, pass 2 register,
//   output register, plus any output stall. Throughput: 1 beat per cycle
//   unless output stalls; each pass is a row of 2*HALF_TAPS tap cells fed
//   the same sample, so every tap does one multiply-add per beat.
// Reset (i_rst_n low, synchronous): clears stage valid flags and the line
//   fill count and sets pass_count to 2; tap partial sums need no clearing.
module gaussian_derivative_fir_cascade #(
    parameter int HALF_TAPS      = 15,
    parameter int SAMPLE_WIDTH   = 16,
    parameter int COEF_FRAC_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    gdfc_in_if.sink                              i_in,
    gdfc_out_if.source                           o_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gdfc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [gdfc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [gdfc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready
);
    localparam int HDEPTH   = 2 * HALF_TAPS;
    localparam int FILL_MAX = 63;   // line fill count saturates here
    localparam int FILL_W   = 6;
    localparam int TAG_W    = gdfc_pkg::TAG_W;
    localparam int OUT_W    = gdfc_pkg::OUT_W;

    // ---------------- configuration port ----------------
    logic                      cfg_hit;
    logic [gdfc_pkg::PC_W-1:0] r_pass_count;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2:2] == gdfc_pkg::REG_PASS_COUNT);
    assign prdata  = cfg_hit ? gdfc_pkg::APB_DATA_W'(r_pass_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_count <= gdfc_pkg::PASS_TWO;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_pass_count <= pwdata[gdfc_pkg::PC_W-1:0];
        end
    end

    // ---------------- stage handshake ----------------
    logic r1_valid, r2_valid, r_out_valid;
    logic out_adv, s2_adv, s1_adv, in_acc;

    assign out_adv    = !r_out_valid || o_out.ready;
    assign s2_adv     = !r2_valid || out_adv;
    assign s1_adv     = !r1_valid || s2_adv;
    assign i_in.ready = s1_adv;
    assign in_acc     = i_in.valid && s1_adv;

    // ---------------- line fill and tag line ----------------
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] fill_eff;
    logic [FILL_W-1:0] n_fill;
    logic              win1, win2;
    logic [TAG_W-1:0]  r_tag [HDEPTH];

    assign fill_eff = i_in.line_start ? '0 : r_fill;
    assign win1     = (fill_eff >= FILL_W'(HDEPTH));
    assign win2     = (32'(fill_eff) >= 32'(2 * HDEPTH));
    assign n_fill   = (fill_eff == FILL_W'(FILL_MAX)) ? fill_eff : fill_eff + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (in_acc) begin
            r_fill <= n_fill;
        end
    end

    // position tags, newest first
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_tag[0] <= i_in.position;
            for (int k = 1; k < HDEPTH; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    // ---------------- pass 1 ----------------
    logic signed [SAMPLE_WIDTH:0] x1;
    logic signed [OUT_W-1:0]      s1;
    logic                         r1_win1, r1_win2;
    logic [TAG_W-1:0]             r1_tag1, r1_tag2;

    assign x1 = $signed({1'b0, i_in.sample});

    gdfc_pass #(
        .IN_W           (SAMPLE_WIDTH + 1),
        .HALF_TAPS      (HALF_TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .SHIFT          (COEF_FRAC_BITS - 16)
    ) u_pass1 (
        .i_clk (i_clk),
        .i_en  (in_acc),
        .i_x   (x1),
        .o_y   (s1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (s1_adv) begin
            r1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_win1 <= win1;
            r1_win2 <= win2;
            r1_tag1 <= r_tag[HALF_TAPS-1];
            r1_tag2 <= r_tag[HDEPTH-1];
        end
    end

    // ---------------- pass 2 ----------------
    logic                    en2;
    logic signed [OUT_W-1:0] s2;
    logic signed [OUT_W-1:0] r2_s1;
    logic                    r2_win1, r2_win2;
    logic [TAG_W-1:0]        r2_tag1, r2_tag2;

    // second row only sees pass-1 values from full windows
    assign en2 = s2_adv && r1_valid && r1_win1;

    gdfc_pass #(
        .IN_W           (OUT_W),
        .HALF_TAPS      (HALF_TAPS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .SHIFT          (COEF_FRAC_BITS)
    ) u_pass2 (
        .i_clk (i_clk),
        .i_en  (en2),
        .i_x   (s1),
        .o_y   (s2)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (s2_adv) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r1_valid) begin
            r2_s1   <= s1;
            r2_win1 <= r1_win1;
            r2_win2 <= r1_win2;
            r2_tag1 <= r1_tag1;
            r2_tag2 <= r1_tag2;
        end
    end

    // ---------------- output register ----------------
    logic                    one_pass;
    logic                    has_result;
    logic signed [OUT_W-1:0] r_out_value;
    logic [TAG_W-1:0]        r_out_pos;

    assign one_pass   = (r_pass_count == gdfc_pkg::PASS_ONE);
    assign has_result = r2_valid && (one_pass ? r2_win1 : r2_win2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && has_result) begin
            r_out_value <= one_pass ? r2_s1 : s2;
            r_out_pos   <= one_pass ? r2_tag1 : r2_tag2;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_value = r_out_value;
    assign o_out.out_position   = r_out_pos;
endmodule

// File: sv/gdfc_checker.sv
module gdfc_port_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [gdfc_pkg::OUT_W-1:0]          i_out_value,
    input logic [gdfc_pkg::TAG_W-1:0]          i_out_position,
    input logic                                i_psel,
    input logic                                i_penable,
    input logic                                i_pwrite,
    input logic [gdfc_pkg::APB_ADDR_W-1:0]     i_paddr,
    input logic [gdfc_pkg::APB_DATA_W-1:0]     i_pwdata,
    input logic [gdfc_pkg::APB_DATA_W-1:0]     i_prdata
);
    // a waiting result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_value) && $stable(i_out_position))
        else $error("result beat changed while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

    // input back-pressure only comes from a blocked result beat
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without a blocked result");

    // pass_count reads back what was written
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && (i_paddr[2:2] == gdfc_pkg::REG_PASS_COUNT)
        ##1 (i_paddr[2:2] == gdfc_pkg::REG_PASS_COUNT)
        |-> i_prdata[gdfc_pkg::PC_W-1:0] == $past(i_pwdata[gdfc_pkg::PC_W-1:0]))
        else $error("pass_count readback mismatch");
endmodule

bind gaussian_derivative_fir_cascade gdfc_port_checker u_gdfc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_value    (o_out.filtered_value),
    .i_out_position (o_out.out_position),
    .i_psel         (psel),
    .i_penable      (penable),
    .i_pwrite       (pwrite),
    .i_paddr        (paddr),
    .i_pwdata       (pwdata),
    .i_prdata       (prdata)
);

// File: verif/gdfc_checker.sv
`timescale 1ns / 1ps

// Watches the sample and result channels plus the APB bus, runs its own
// derivative-of-Gaussian filter model and compares every result beat.
module gdfc_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    gdfc_in_if                              i_in,
    gdfc_out_if                             i_out,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [gdfc_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [gdfc_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic                            i_pready,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int HIST   = 30;   // previous samples kept per pass
    localparam int CENTRE = 15;   // window center tap
    localparam int FILL_TOP = 63;
    localparam int OUT_W  = gdfc_pkg::OUT_W;
    localparam int TAG_W  = gdfc_pkg::TAG_W;
    localparam int PC_W   = gdfc_pkg::PC_W;

    // |k| per tap distance, sigma 5, Q0.24
    localparam longint KMAG [0:15] = '{
        0, 52485, 98857, 134174, 155527, 162384, 156379, 140673,
        119100, 95369, 72465, 52375, 36069, 23700, 14874, 8922
    };

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic [TAG_W-1:0]        pos;
    } t_dog_result;

    t_dog_result             expected_q [$];
    logic [PC_W-1:0]         pass_sel;
    logic [15:0]             raw_hist   [HIST];
    logic signed [OUT_W-1:0] stage_hist [HIST];
    logic [TAG_W-1:0]        tag_hist   [HIST];
    int                      fill_cnt;

    // tap 0 is the oldest sample of the window, tap 30 the newest
    function automatic longint tap_weight(input int t);
        int off;
        int a;
        off = t - CENTRE;
        a   = (off < 0) ? -off : off;
        return (off < 0) ? KMAG[a] : -KMAG[a];
    endfunction

    function automatic logic signed [OUT_W-1:0] clip32(input longint v);
        if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
        return v[OUT_W-1:0];
    endfunction

    task automatic clear_line();
        for (int k = 0; k < HIST; k++) begin
            raw_hist[k]   = '0;
            stage_hist[k] = '0;
            tag_hist[k]   = '0;
        end
        fill_cnt = 0;
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        o_fail_count++;
    endtask

    // One accepted sample beat: update line state, queue the expected result
    task automatic filter_beat(input logic [15:0] smp, input logic [TAG_W-1:0] tag,
                               input logic ls);
        logic                    full1;
        logic                    full2;
        logic [TAG_W-1:0]        tag1;
        logic [TAG_W-1:0]        tag2;
        logic signed [OUT_W-1:0] s1;
        logic signed [OUT_W-1:0] s2;
        longint                  acc;
        t_dog_result             r;
        if (ls) clear_line();
        full1 = (fill_cnt >= HIST);
        full2 = (fill_cnt >= 2 * HIST);
        tag1  = tag_hist[CENTRE - 1];
        tag2  = tag_hist[HIST - 1];
        s1    = '0;
        s2    = '0;
        if (full1) begin
            acc = tap_weight(HIST) * longint'(smp);
            for (int k = 0; k < HIST; k++)
                acc += tap_weight(HIST - 1 - k) * longint'(raw_hist[k]);
            s1 = clip32(acc >>> 8);
            if (full2) begin
                acc = tap_weight(HIST) * longint'(s1);
                for (int k = 0; k < HIST; k++)
                    acc += tap_weight(HIST - 1 - k) * longint'(stage_hist[k]);
                s2 = clip32(acc >>> 24);
            end
            for (int k = HIST - 1; k > 0; k--) stage_hist[k] = stage_hist[k-1];
            stage_hist[0] = s1;
        end
        for (int k = HIST - 1; k > 0; k--) begin
            raw_hist[k] = raw_hist[k-1];
            tag_hist[k] = tag_hist[k-1];
        end
        raw_hist[0] = smp;
        tag_hist[0] = tag;
        if (fill_cnt < FILL_TOP) fill_cnt++;

        // codes other than one pass all mean two passes
        if (pass_sel == gdfc_pkg::PASS_ONE) begin
            if (full1) begin
                r.value = s1;
                r.pos   = tag1;
                expected_q = {expected_q, r};
            end
        end else if (full2) begin
            r.value = s2;
            r.pos   = tag2;
            expected_q = {expected_q, r};
        end
    endtask

    always @(posedge i_clk) begin : mon
        t_dog_result exp_r;
        if (!i_rst_n) begin
            clear_line();
            pass_sel = gdfc_pkg::PASS_TWO;
            expected_q.delete();
            o_fail_count = 0;
        end else begin
            // result beat against oldest expectation
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d tag %0d",
                                              i_out.filtered_value, i_out.out_position));
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_out.filtered_value !== exp_r.value)
                        report_mismatch($sformatf("tag %0d: value %0d, wanted %0d",
                                                  exp_r.pos, i_out.filtered_value,
                                                  exp_r.value));
                    if (i_out.out_position !== exp_r.pos)
                        report_mismatch($sformatf("position %0d, wanted %0d",
                                                  i_out.out_position, exp_r.pos));
                end
            end
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == gdfc_pkg::REG_PASS_COUNT)
                pass_sel = i_pwdata[PC_W-1:0];
            // sample beat
            if (i_in.valid && i_in.ready)
                filter_beat(i_in.sample, i_in.position, i_in.line_start);
        end
        o_pending = expected_q.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int PC_W       = gdfc_pkg::PC_W;
    localparam int APB_ADDR_W = gdfc_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = gdfc_pkg::APB_DATA_W;
    localparam logic [PC_W-1:0]       PASS_UNUSED_LO = 2'd0;
    localparam logic [PC_W-1:0]       PASS_UNUSED_HI = 2'd3;
    localparam logic [APB_ADDR_W-1:0] PASS_COUNT_ADDR = {gdfc_pkg::REG_PASS_COUNT, 2'b00};
    localparam int SETTLE      = 12;    // cycles past last result before a write
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off
    localparam int PHASE_ITEMS = 40;
    localparam int N_PHASES    = 6;

    // sample shapes for a line
    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_RAILS,
        SHAPE_STEPS,
        SHAPE_LOW
    } t_line_shape;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;

    gdfc_in_if #(.SAMPLE_WIDTH(16)) in_bus ();
    gdfc_out_if                     out_bus ();

    gaussian_derivative_fir_cascade i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gdfc_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_bus),
        .i_out        (out_bus),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("gaussian_derivative_fir_cascade test failed");
        $finish;
    end

    // Result receiver: random on/off runs, free-running stretches, long hold-off
    bit rx_free  = 1'b0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_run_left = 0;
    bit rx_on = 1'b1;

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_bus.ready <= 1'b0;
        end else if (rx_free) begin
            out_bus.ready <= 1'b1;
        end else begin
            if (rx_run_left == 0) begin
                rx_on = !rx_on;
                rx_run_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end
            rx_run_left--;
            out_bus.ready <= rx_on;
        end
    end

    // Sender state
    int          burst_left = 0;
    bit          tx_free    = 1'b0;
    logic [15:0] pos_ctr;
    logic [15:0] step_level;

    task automatic write_pass_count(input logic [PC_W-1:0] pc);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PASS_COUNT_ADDR;
        pwdata  <= (32'($urandom()) & ~32'h3) | 32'(pc);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_beat(input logic [15:0] smp, input logic [15:0] pos,
                             input logic ls);
        in_bus.valid      <= 1'b1;
        in_bus.sample     <= smp;
        in_bus.position   <= pos;
        in_bus.line_start <= ls;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
    endtask

    // Burst pacing: gap only between bursts, so valid never drops and rises at once
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0 || tx_free) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Stop offering and wait until every expected result beat is out
    task automatic drain(input int extra);
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (extra) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_sample(input t_line_shape shape);
        case (shape)
            SHAPE_RAILS: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            SHAPE_STEPS: begin
                if ($urandom_range(0, 11) == 0) step_level = 16'($urandom());
                return step_level;
            end
            SHAPE_LOW:   return 16'($urandom_range(0, 255));
            default:     return 16'($urandom());
        endcase
    endfunction

    // Sends one line; fresh = start it with a line_start beat
    task automatic send_line(input int len, input bit fresh, inout int sent);
        t_line_shape shape;
        logic        ls;
        shape = t_line_shape'($urandom_range(0, 3));
        if (fresh) pos_ctr = 16'($urandom());
        for (int i = 0; i < len; i++) begin
            pace();
            ls = (i == 0) ? fresh : ($urandom_range(0, 99) == 0);
            pos_ctr = ($urandom_range(0, 19) == 0) ? 16'($urandom()) : pos_ctr + 16'd1;
            send_beat(pick_sample(shape), pos_ctr, ls);
            sent++;
        end
    endtask

    logic [PC_W-1:0] phase_pc [N_PHASES] = '{gdfc_pkg::PASS_TWO, gdfc_pkg::PASS_ONE,
                                             PASS_UNUSED_HI, gdfc_pkg::PASS_ONE,
                                             PASS_UNUSED_LO, gdfc_pkg::PASS_TWO};

    initial begin
        int sent;
        int len;
        in_bus.valid      <= 1'b0;
        in_bus.sample     <= '0;
        in_bus.position   <= '0;
        in_bus.line_start <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        i_rst_n           <= 1'b0;
        pos_ctr    = '0;
        step_level = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: one pass, full-scale edge gives the largest positive response
        write_pass_count(gdfc_pkg::PASS_ONE);
        tx_free = 1'b1;
        for (int i = 0; i < 31; i++)
            send_beat((i < 15) ? 16'hffff : 16'h0000,
                      (i == 0) ? 16'hffff : 16'(i), (i == 0));
        // window slides past the edge; the sent tags hit the rails
        send_beat(16'h0000, 16'h0000, 1'b0);
        send_beat(16'hffff, 16'hffff, 1'b0);
        // line start in a full window, a one-sample line, then a two-sample line
        send_beat(16'hffff, 16'h8000, 1'b1);
        send_beat(16'h0000, 16'h7fff, 1'b1);
        send_beat(16'h5555, 16'haaaa, 1'b1);
        send_beat(16'haaaa, 16'h5555, 1'b0);
        tx_free = 1'b0;
        drain(SETTLE);

        // Random phases over all pass_count codes
        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_pass_count(phase_pc[ph]);
            rx_free = (ph == 3);
            tx_free = (ph == 3);
            sent = 0;
            // long receiver hold-off while the sender keeps offering
            if (ph == 1) hold_req = hold_req + 1;
            // first line may carry on from the last phase: setting changes mid-line
            send_line($urandom_range(31, 90), ($urandom_range(0, 2) != 0), sent);
            // sender pause mid-phase: let every expected result come out
            if (ph == 4) drain(0);
            while (sent < PHASE_ITEMS) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30)
                                                  : $urandom_range(31, 90);
                send_line(len, 1'b1, sent);
            end
            drain(SETTLE);
        end

        if (fail_count == 0) begin
            $display("gaussian_derivative_fir_cascade test passed");
        end else begin
            $display("gaussian_derivative_fir_cascade test failed");
        end
        $finish;
    end

endmodule

// File: gaussian_derivative_fir_cascade.f
sv/gdfc_pkg.sv
sv/gdfc_in_if.sv
sv/gdfc_out_if.sv
sv/gdfc_cell.sv
sv/gdfc_pass.sv
sv/gaussian_derivative_fir_cascade.sv
sv/gdfc_checker.sv
verif/gdfc_checker.sv
verif/tb.sv
